// ===== rtl/srrw_pkg.sv =====
// Package for the selective-repeat receive window: segment geometry, codes,
// the result struct and the segment length/offset helpers.
// No dependencies.
package srrw_pkg;

  localparam int SEG_BYTES        = 1024;
  localparam int SEG_SHIFT        = $clog2(SEG_BYTES);
  localparam int DEF_WINDOW_DEPTH = 16;

  localparam int OFF_W  = 32;
  localparam int LEN_W  = 11;
  localparam int SLOT_W = 4;
  localparam int SEG_W  = OFF_W + 1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_ARRIVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_STORE   = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_ARRIVE,
    ST_DELIVER,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [SLOT_W-1:0]  slot;
    logic               complete;
  } res_t;

  // bytes of segment seg, at most one full segment, zero past end of file
  function automatic logic [LEN_W-1:0] seg_len(input logic [SEG_W-1:0] seg,
                                               input logic [OFF_W-1:0] fsize);
    logic [SEG_W-1:0] fs_hi;
    logic [LEN_W-1:0] res;
    fs_hi = SEG_W'(fsize >> SEG_SHIFT);
    if (seg < fs_hi) begin
      res = LEN_W'(SEG_BYTES);
    end else if (seg == fs_hi) begin
      res = LEN_W'(fsize[SEG_SHIFT-1:0]);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic logic [OFF_W-1:0] seg_offset(input logic [SEG_W-1:0] seg);
    return OFF_W'({seg, {SEG_SHIFT{1'b0}}});
  endfunction

endpackage

// ===== rtl/selective_repeat_receive_window.sv =====
// Selective-repeat receive window, top level.
// Depends on srrw_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per command:
//   start, tick or segment arrival. Output channel (out_valid_o / out_stall_i)
//   gives request, store and deliver words; last_o marks the final word
//   caused by one input word. file_size is written through cfg_we_i /
//   cfg_wdata_i; the user must write it only while the block is idle, which
//   the block itself does not enforce. A start needs no sequencer steps; a
//   tick walks the window slots, one slot per cycle through the slot cursor
//   unless the output holds it, then does one end check and one flush; an
//   arrival does one check, one step per delivery, one end check, one flush.
//   A result word waits in a pending register and moves to the output
//   register when the next result is found, or at the flush step for the last one.
//   A finished word may wait in the output register while a new input word
//   is accepted. When the receiver stalls, the sequencer holds at its next
//   result until the output register frees up.
//   Reset clears the window (no start seen: ticks give nothing, arrivals are
//   dropped) and sets file_size to 1.
module selective_repeat_receive_window
  import srrw_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [OFF_W-1:0]  seg_offset_i,
  input  logic [LEN_W-1:0]  seg_length_i,
  input  logic              source_ok_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [OFF_W-1:0]  offset_o,
  output logic [LEN_W-1:0]  length_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              complete_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic [OFF_W-1:0]  cfg_wdata_i
);

  localparam int SW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WCW = $clog2(WINDOW_DEPTH + 1);

  state_e                  state_q, state_d;
  logic [OFF_W-1:0]        ns_q;
  logic [SW-1:0]           head_q;
  logic [WCW-1:0]          wc_q;
  logic [WINDOW_DEPTH-1:0] marks_q;
  logic [OFF_W-1:0]        fs_q;
  logic [WCW-1:0]          idx_q;
  logic [SW-1:0]           cur_q;
  logic [OFF_W-1:0]        soff_q;
  logic [LEN_W-1:0]        slen_q;
  logic                    sok_q;
  logic                    pend_valid_q;
  res_t                    pend_q;
  logic                    out_valid_q;
  res_t                    out_q;
  logic                    out_last_q;

  logic             in_acc, out_free, can_emit;
  logic             emit, step, flush_move;
  res_t             new_res;
  logic [SW-1:0]    rd_slot, arr_slot, head_inc, cur_inc;
  logic             mark_rd;
  logic [SEG_W-1:0] segs, tick_seg, diff, arr_sum;
  logic [OFF_W-1:0] seg_a, ns_inc;
  logic             in_win, arr_ok, del_go, tick_done, shrink;
  logic [WCW-1:0]   wc_new, wc_start;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign can_emit = !pend_valid_q || out_free;

  assign segs     = (SEG_W'(fs_q) + SEG_W'(SEG_BYTES - 1)) >> SEG_SHIFT;
  assign wc_start = (segs >= SEG_W'(WINDOW_DEPTH)) ? WCW'(WINDOW_DEPTH) : WCW'(segs);

  assign head_inc = (head_q == SW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign cur_inc  = (cur_q == SW'(WINDOW_DEPTH - 1)) ? '0 : cur_q + 1'b1;

  // arrival: segment index, distance from window head, slot
  assign seg_a   = soff_q >> SEG_SHIFT;
  assign diff    = SEG_W'(seg_a) - SEG_W'(ns_q);
  assign in_win  = !diff[SEG_W-1] && (diff < SEG_W'(wc_q));
  assign arr_sum = SEG_W'(head_q) + SEG_W'(diff[SW-1:0]);
  assign arr_slot = (arr_sum >= SEG_W'(WINDOW_DEPTH)) ?
                    SW'(arr_sum - SEG_W'(WINDOW_DEPTH)) : SW'(arr_sum);

  assign tick_seg = SEG_W'(ns_q) + SEG_W'(idx_q);

  assign ns_inc = ns_q + 1'b1;
  assign shrink = (SEG_W'(ns_inc) + SEG_W'(wc_q)) >= segs;
  assign wc_new = shrink ? wc_q - 1'b1 : wc_q;

  always_comb begin
    case (state_q)
      ST_TICK:    rd_slot = cur_q;
      ST_ARRIVE:  rd_slot = arr_slot;
      default:    rd_slot = head_q;
    endcase
  end
  assign mark_rd = marks_q[rd_slot];

  assign tick_done = idx_q >= wc_q;
  assign arr_ok    = sok_q && in_win && !mark_rd;
  assign del_go    = (wc_q != '0) && mark_rd;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(op_i))
            OP_TICK:   state_d = ST_TICK;
            OP_ARRIVE: state_d = ST_ARRIVE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (tick_done) state_d = ST_FLUSH;
      end
      ST_ARRIVE: begin
        if (!arr_ok || can_emit) state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!del_go) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    emit       = 1'b0;
    step       = 1'b0;
    flush_move = 1'b0;
    new_res    = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_TICK: begin
        new_res.kind     = KIND_REQUEST;
        new_res.offset   = seg_offset(tick_seg);
        new_res.length   = seg_len(tick_seg, fs_q);
        new_res.slot     = SLOT_W'(cur_q);
        new_res.complete = (wc_q == '0);
        if (!tick_done) begin
          if (mark_rd) begin
            step = 1'b1;
          end else if (can_emit) begin
            emit = 1'b1;
            step = 1'b1;
          end
        end
      end
      ST_ARRIVE: begin
        new_res.kind     = KIND_STORE;
        new_res.offset   = soff_q;
        new_res.length   = slen_q;
        new_res.slot     = SLOT_W'(arr_slot);
        new_res.complete = (wc_q == '0);
        if (arr_ok && can_emit) emit = 1'b1;
      end
      ST_DELIVER: begin
        new_res.kind     = KIND_DELIVER;
        new_res.offset   = seg_offset(SEG_W'(ns_q));
        new_res.length   = seg_len(SEG_W'(ns_q), fs_q);
        new_res.slot     = SLOT_W'(head_q);
        new_res.complete = (wc_new == '0);
        if (del_go && can_emit) begin
          emit = 1'b1;
          step = 1'b1;
        end
      end
      ST_FLUSH: begin
        flush_move = pend_valid_q && out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ns_q         <= '0;
      head_q       <= '0;
      wc_q         <= '0;
      marks_q      <= '0;
      fs_q         <= OFF_W'(1);
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) fs_q <= cfg_wdata_i;
      if (in_acc && (op_e'(op_i) == OP_START)) begin
        marks_q <= '0;
        ns_q    <= '0;
        head_q  <= '0;
        wc_q    <= wc_start;
      end
      if (state_q == ST_ARRIVE && emit) marks_q[arr_slot] <= 1'b1;
      if (state_q == ST_DELIVER && step) begin
        marks_q[head_q] <= 1'b0;
        ns_q            <= ns_inc;
        wc_q            <= wc_new;
        head_q          <= head_inc;
      end
      if ((emit && pend_valid_q) || flush_move) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (emit) pend_valid_q <= 1'b1;
      else if (flush_move) pend_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= '0;
      cur_q  <= head_q;
      soff_q <= seg_offset_i;
      slen_q <= seg_length_i;
      sok_q  <= source_ok_i;
    end
    if (state_q == ST_TICK && step) begin
      idx_q <= idx_q + 1'b1;
      cur_q <= cur_inc;
    end
    if (emit) pend_q <= new_res;
    if (emit && pend_valid_q) begin
      out_q      <= pend_q;
      out_last_q <= 1'b0;
    end else if (flush_move) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign offset_o    = out_q.offset;
  assign length_o    = out_q.length;
  assign slot_o      = out_q.slot;
  assign complete_o  = out_q.complete;
  assign last_o      = out_last_q;

`ifndef SYNTH
  a_wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WCW'(WINDOW_DEPTH))
    else $error("window count above depth");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !pend_valid_q)
    else $error("held result left behind when ready");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && pend_valid_q) |-> out_free)
    else $error("output register overwritten");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == OP_START) |=> (ns_q == '0 && head_q == '0))
    else $error("start did not reset window head");
`endif

endmodule
